// File: design/cpmc_pkg.sv
// Shared types for the cluster pair merge check block.
// Request and response payload structs; no dependencies.
`timescale 1ns / 1ps

package cpmc_pkg;

   // Width of every id field on the channels
   localparam int IdW = 16;

   typedef logic [IdW-1:0] id_type;

   typedef struct packed {
      id_type first_ring_a;
      id_type first_ring_b;
      id_type first_ring_c;
      id_type first_ring_d;
      id_type first_spindle_a;
      id_type first_spindle_b;
      id_type second_ring_a;
      id_type second_ring_b;
      id_type second_ring_c;
      id_type second_ring_d;
      id_type second_spindle_a;
      id_type second_spindle_b;
   } req_type;

   typedef struct packed {
      logic   is_match;
      id_type shared_ring_lo;
      id_type shared_ring_hi;
      id_type other_ring_0;
      id_type other_ring_1;
      id_type other_ring_2;
      id_type other_ring_3;
      id_type other_spindle_lo;
      id_type other_spindle_hi;
      id_type shared_spindle;
   } rsp_type;

endpackage

// File: design/cpmc_req_if.sv
// Request channel interface: valid, ready and a cluster pair payload.
// Depends on cpmc_pkg.
`timescale 1ns / 1ps

interface cpmc_req_if;
   import cpmc_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/cpmc_rsp_if.sv
// Response channel interface: valid, ready and a merge result payload.
// Depends on cpmc_pkg.
`timescale 1ns / 1ps

interface cpmc_rsp_if;
   import cpmc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/cpmc_sort4.sv
// Two-stage pipelined sorting network for four ids, with side payload.
// Stand-alone; valid/ready handshake on both sides.
`timescale 1ns / 1ps

module cpmc_sort4 #(
   parameter int W     = 16,
   parameter int SideW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [W-1:0]     in_val [4],
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [W-1:0]     out_val [4],
   output logic [SideW-1:0] out_side
);

   logic             sa_valid_ff;
   logic             sa_valid_in;
   logic [W-1:0]     sa_val_ff [4];
   logic [W-1:0]     sa_val_in [4];
   logic [SideW-1:0] sa_side_ff;
   logic             sb_valid_ff;
   logic             sb_valid_in;
   logic [W-1:0]     sb_val_ff [4];
   logic [W-1:0]     sb_val_in [4];
   logic [SideW-1:0] sb_side_ff;
   logic             sa_ready;
   logic             sb_ready;
   logic [W-1:0]     mid [4];

   // Stage ready: empty, or the next stage takes the current content
   assign sb_ready = !sb_valid_ff || out_ready;
   assign sa_ready = !sa_valid_ff || sb_ready;
   assign in_ready = sa_ready;

   // First level: order pairs (0,1) and (2,3)
   always_comb begin
      sa_valid_in  = in_valid;
      sa_val_in[0] = (in_val[0] > in_val[1]) ? in_val[1] : in_val[0];
      sa_val_in[1] = (in_val[0] > in_val[1]) ? in_val[0] : in_val[1];
      sa_val_in[2] = (in_val[2] > in_val[3]) ? in_val[3] : in_val[2];
      sa_val_in[3] = (in_val[2] > in_val[3]) ? in_val[2] : in_val[3];
   end

   // Second and third levels: (0,2), (1,3), then (1,2)
   always_comb begin
      sb_valid_in  = sa_valid_ff;
      mid[0]       = (sa_val_ff[0] > sa_val_ff[2]) ? sa_val_ff[2] : sa_val_ff[0];
      mid[2]       = (sa_val_ff[0] > sa_val_ff[2]) ? sa_val_ff[0] : sa_val_ff[2];
      mid[1]       = (sa_val_ff[1] > sa_val_ff[3]) ? sa_val_ff[3] : sa_val_ff[1];
      mid[3]       = (sa_val_ff[1] > sa_val_ff[3]) ? sa_val_ff[1] : sa_val_ff[3];
      sb_val_in[0] = mid[0];
      sb_val_in[1] = (mid[1] > mid[2]) ? mid[2] : mid[1];
      sb_val_in[2] = (mid[1] > mid[2]) ? mid[1] : mid[2];
      sb_val_in[3] = mid[3];
   end

   // Advance stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else if (sa_ready) begin
         sa_valid_ff <= sa_valid_in;
      end
      if (sa_ready && in_valid) begin
         sa_val_ff  <= sa_val_in;
         sa_side_ff <= in_side;
      end
   end

   // Advance stage B (output register)
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else if (sb_ready) begin
         sb_valid_ff <= sb_valid_in;
      end
      if (sb_ready && sa_valid_ff) begin
         sb_val_ff  <= sb_val_in;
         sb_side_ff <= sa_side_ff;
      end
   end

   assign out_valid = sb_valid_ff;
   assign out_val   = sb_val_ff;
   assign out_side  = sb_side_ff;

endmodule

// File: design/cluster_pair_merge_check_top.sv
// Top level of the cluster pair merge check block.
// Depends on cpmc_pkg, cpmc_req_if, cpmc_rsp_if and cpmc_sort4.
`timescale 1ns / 1ps

// Usage:
//   req_if carries one pair of six-particle clusters per request (four ring
//   ids and two spindle ids each). rsp_if returns one result per request:
//   is_match and nine ids (shared rings, unshared rings, unshared spindles,
//   shared spindle), all zero when the pair does not merge.
//   Both channels move a request on a clock edge with valid and ready high.
//   Pipeline: five register stages, compare, select, pick, and two sorting
//   network stages, lie between req_if and rsp_if.
//   Throughput: one request per cycle while rsp_if.ready is high; every
//   stage holds its own valid bit and takes new data when empty or when
//   its content moves on, so bubbles collapse while the receiver stalls.
//   When rsp_if.ready is low the output register holds its result; the
//   stages behind it keep filling until all five are occupied, then
//   req_if.ready drops. Nothing is lost or repeated.
//   Reset (synchronous, active high) empties all stages; there is no
//   other state. ID_WIDTH sets how many low id bits are compared; higher
//   bits are ignored and results are zero-extended.

module cluster_pair_merge_check_top #(
   parameter int ID_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   cpmc_req_if.sink    req_if,
   cpmc_rsp_if.source  rsp_if
);
   import cpmc_pkg::*;

   localparam int CmpW  = (ID_WIDTH < IdW) ? ID_WIDTH : IdW;
   localparam int SideW = 1 + 5 * CmpW;

   typedef logic [CmpW-1:0] cid_type;

   // ---------------- stage 1: equality matrices ----------------
   logic    s1_valid_ff, s1_valid_in, s1_ready;
   cid_type s1_a_ff [6];
   cid_type s1_b_ff [6];
   cid_type s1_a_in [6];
   cid_type s1_b_in [6];
   logic [3:0]  s1_speq_ff, s1_speq_in;
   logic [15:0] s1_rgeq_ff, s1_rgeq_in;

   // ---------------- stage 2: spindle and shared ring select ----------------
   logic    s2_valid_ff, s2_valid_in, s2_ready;
   cid_type s2_a_ff [4];
   cid_type s2_b_ff [4];
   cid_type s2_sh0_ff, s2_sh0_in;
   cid_type s2_sh1_ff, s2_sh1_in;
   cid_type s2_osp0_ff, s2_osp0_in;
   cid_type s2_osp1_ff, s2_osp1_in;
   cid_type s2_scom_ff, s2_scom_in;
   logic    s2_ok_ff, s2_ok_in;

   // ---------------- stage 3: unshared pick and pair ordering ----------------
   logic    s3_valid_ff, s3_valid_in, s3_ready;
   cid_type s3_oth_ff [4];
   cid_type s3_oth_in [4];
   logic [SideW-1:0] s3_side_ff, s3_side_in;

   logic             srt_ready;
   logic             srt_valid;
   cid_type          srt_val [4];
   logic [SideW-1:0] srt_side;

   // Stage ready chain
   assign s3_ready     = !s3_valid_ff || srt_ready;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_if.ready = s1_ready;

   // Truncate ids and compare every spindle and ring pair
   always_comb begin
      s1_valid_in = req_if.valid;
      s1_a_in[0]  = req_if.data.first_ring_a[CmpW-1:0];
      s1_a_in[1]  = req_if.data.first_ring_b[CmpW-1:0];
      s1_a_in[2]  = req_if.data.first_ring_c[CmpW-1:0];
      s1_a_in[3]  = req_if.data.first_ring_d[CmpW-1:0];
      s1_a_in[4]  = req_if.data.first_spindle_a[CmpW-1:0];
      s1_a_in[5]  = req_if.data.first_spindle_b[CmpW-1:0];
      s1_b_in[0]  = req_if.data.second_ring_a[CmpW-1:0];
      s1_b_in[1]  = req_if.data.second_ring_b[CmpW-1:0];
      s1_b_in[2]  = req_if.data.second_ring_c[CmpW-1:0];
      s1_b_in[3]  = req_if.data.second_ring_d[CmpW-1:0];
      s1_b_in[4]  = req_if.data.second_spindle_a[CmpW-1:0];
      s1_b_in[5]  = req_if.data.second_spindle_b[CmpW-1:0];
      for (int k = 0; k < 2; k++) begin
         for (int l = 0; l < 2; l++) begin
            s1_speq_in[k*2+l] = (s1_a_in[4+k] == s1_b_in[4+l]);
         end
      end
      for (int k = 0; k < 4; k++) begin
         for (int l = 0; l < 4; l++) begin
            s1_rgeq_in[k*4+l] = (s1_a_in[k] == s1_b_in[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_ready && req_if.valid) begin
         s1_a_ff    <= s1_a_in;
         s1_b_ff    <= s1_b_in;
         s1_speq_ff <= s1_speq_in;
         s1_rgeq_ff <= s1_rgeq_in;
      end
   end

   // Find the shared spindle, check exclusion, pick the shared rings
   logic [2:0] rowcnt [4];
   logic [4:0] rgcnt;
   logic       excl_ok;

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_scom_in  = (s1_speq_ff[0] || s1_speq_ff[1]) ? s1_a_ff[4] : s1_a_ff[5];
      s2_osp0_in  = (s1_a_ff[4] == s2_scom_in) ? s1_a_ff[5] : s1_a_ff[4];
      s2_osp1_in  = (s1_b_ff[4] == s2_scom_in) ? s1_b_ff[5] : s1_b_ff[4];
      excl_ok     = 1'b1;
      for (int k = 0; k < 6; k++) begin
         if (s2_osp0_in == s1_b_ff[k] || s2_osp1_in == s1_a_ff[k]) begin
            excl_ok = 1'b0;
         end
      end
      // Row-major scan: first and second equal ring pairs, by first-cluster id
      rgcnt      = '0;
      s2_sh0_in  = '0;
      s2_sh1_in  = '0;
      for (int k = 0; k < 4; k++) begin
         rowcnt[k] = 3'($countones(s1_rgeq_ff[k*4 +: 4]));
         if (rowcnt[k] != 3'd0) begin
            if (rgcnt == 5'd0) begin
               s2_sh0_in = s1_a_ff[k];
               if (rowcnt[k] >= 3'd2) begin
                  s2_sh1_in = s1_a_ff[k];
               end
            end else if (rgcnt == 5'd1) begin
               s2_sh1_in = s1_a_ff[k];
            end
         end
         rgcnt = rgcnt + 5'(rowcnt[k]);
      end
      s2_ok_in = ($countones(s1_speq_ff) == 1) && excl_ok && (rgcnt == 5'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_a_ff    <= s1_a_ff[0:3];
         s2_b_ff    <= s1_b_ff[0:3];
         s2_sh0_ff  <= s2_sh0_in;
         s2_sh1_ff  <= s2_sh1_in;
         s2_osp0_ff <= s2_osp0_in;
         s2_osp1_ff <= s2_osp1_in;
         s2_scom_ff <= s2_scom_in;
         s2_ok_ff   <= s2_ok_in;
      end
   end

   // Pick the two unshared rings of each cluster, order the pairs, zero on no match
   logic [2:0] na, nb;
   cid_type    pa [2];
   cid_type    pb [2];
   logic       ok3;
   cid_type    sh_lo, sh_hi, sp_lo, sp_hi, scom3;

   always_comb begin
      s3_valid_in = s2_valid_ff;
      na = '0;
      nb = '0;
      pa[0] = '0;
      pa[1] = '0;
      pb[0] = '0;
      pb[1] = '0;
      for (int k = 0; k < 4; k++) begin
         if (s2_a_ff[k] != s2_sh0_ff && s2_a_ff[k] != s2_sh1_ff) begin
            if (na == 3'd0) begin
               pa[0] = s2_a_ff[k];
            end else if (na == 3'd1) begin
               pa[1] = s2_a_ff[k];
            end
            na = na + 3'd1;
         end
         if (s2_b_ff[k] != s2_sh0_ff && s2_b_ff[k] != s2_sh1_ff) begin
            if (nb == 3'd0) begin
               pb[0] = s2_b_ff[k];
            end else if (nb == 3'd1) begin
               pb[1] = s2_b_ff[k];
            end
            nb = nb + 3'd1;
         end
      end
      ok3   = s2_ok_ff && (na == 3'd2) && (nb == 3'd2);
      sh_lo = (s2_sh0_ff > s2_sh1_ff) ? s2_sh1_ff : s2_sh0_ff;
      sh_hi = (s2_sh0_ff > s2_sh1_ff) ? s2_sh0_ff : s2_sh1_ff;
      sp_lo = (s2_osp0_ff > s2_osp1_ff) ? s2_osp1_ff : s2_osp0_ff;
      sp_hi = (s2_osp0_ff > s2_osp1_ff) ? s2_osp0_ff : s2_osp1_ff;
      scom3 = s2_scom_ff;
      if (!ok3) begin
         sh_lo = '0;
         sh_hi = '0;
         sp_lo = '0;
         sp_hi = '0;
         scom3 = '0;
         pa[0] = '0;
         pa[1] = '0;
         pb[0] = '0;
         pb[1] = '0;
      end
      s3_oth_in[0] = pa[0];
      s3_oth_in[1] = pa[1];
      s3_oth_in[2] = pb[0];
      s3_oth_in[3] = pb[1];
      s3_side_in   = {ok3, sh_lo, sh_hi, sp_lo, sp_hi, scom3};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s3_valid_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_oth_ff  <= s3_oth_in;
         s3_side_ff <= s3_side_in;
      end
   end

   // Sort the four unshared rings; the output register sits inside
   cpmc_sort4 #(
      .W     (CmpW),
      .SideW (SideW)
   ) u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_ready  (srt_ready),
      .in_val    (s3_oth_ff),
      .in_side   (s3_side_ff),
      .out_valid (srt_valid),
      .out_ready (rsp_if.ready),
      .out_val   (srt_val),
      .out_side  (srt_side)
   );

   // Drive the response, zero-extending ids to the channel width
   assign rsp_if.valid                 = srt_valid;
   assign rsp_if.data.is_match         = srt_side[SideW-1];
   assign rsp_if.data.shared_ring_lo   = IdW'(srt_side[4*CmpW +: CmpW]);
   assign rsp_if.data.shared_ring_hi   = IdW'(srt_side[3*CmpW +: CmpW]);
   assign rsp_if.data.other_ring_0     = IdW'(srt_val[0]);
   assign rsp_if.data.other_ring_1     = IdW'(srt_val[1]);
   assign rsp_if.data.other_ring_2     = IdW'(srt_val[2]);
   assign rsp_if.data.other_ring_3     = IdW'(srt_val[3]);
   assign rsp_if.data.other_spindle_lo = IdW'(srt_side[2*CmpW +: CmpW]);
   assign rsp_if.data.other_spindle_hi = IdW'(srt_side[CmpW +: CmpW]);
   assign rsp_if.data.shared_spindle   = IdW'(srt_side[0 +: CmpW]);

endmodule
